// ----- src/chf_pkg.sv -----
// Shared types and constants for the compass heading pipeline.
// No dependencies.
package chf_pkg;

    typedef logic [0:0] cfg_idx_t;

    localparam cfg_idx_t CFG_SWAP_X_Y    = 1'b0;
    localparam cfg_idx_t CFG_DECLINATION = 1'b1;

    localparam int CFG_DATA_W  = 16;
    localparam int SAMPLE_W    = 16;
    localparam int HEADING_W   = 16;
    localparam int ANGLE_W     = 33;
    localparam int ATAN_LEN    = 24;

    typedef logic [31:0] atan_word_t;

    // atan(2^-i) in units of 2^-32 turn, rounded
    localparam atan_word_t ATAN_TURN [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ----- src/compass_heading_from_field.sv -----
// Compass heading from one X/Y field sample pair: atan2(-x, y) by CORDIC.
// Stages: setup, one stage per CORDIC step, scale multiply, rounding plus
// declination, wrap into 0..360 degrees; each stage has its own valid bit.
// Throughput: one word per cycle unless m_tready stalls the output.
// Reset: aresetn (synchronous, active low) empties the pipeline and clears
// the swap and declination registers. Depends on chf_pkg.
module compass_heading_from_field #(
    parameter int ANGLE_ITERATIONS  = 16,
    parameter int HEADING_FRAC_BITS = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // x_sample, y_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [chf_pkg::HEADING_W-1:0]     m_tdata,   // heading
    input  logic                              cfg_we,
    input  chf_pkg::cfg_idx_t                 cfg_addr,
    input  logic [chf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import chf_pkg::*;

    localparam int N      = ANGLE_ITERATIONS;
    localparam int FULL   = 360 << HEADING_FRAC_BITS;
    localparam int FW     = $clog2(FULL) + 2;
    localparam int PW     = ANGLE_W + FW;
    localparam int HW     = PW - 32;
    localparam int SW     = ((HW > CFG_DATA_W) ? HW : CFG_DATA_W) + 1;
    localparam int VW     = N + 19;
    localparam int AW     = SAMPLE_W + 1;

    localparam logic signed [ANGLE_W-1:0] Z_HALF = {1'b0, 1'b1, {(ANGLE_W-2){1'b0}}};
    localparam logic signed [FW-1:0]      FULL_S = FW'(FULL);
    localparam logic signed [SW:0]        FULL_F = (SW+1)'(FULL);
    localparam logic [PW-1:0]             ROUND_C = PW'(33'h080000000);

    logic                        swap_reg;
    logic signed [CFG_DATA_W-1:0] decl_reg;

    logic [N:0]                  v_reg;
    logic [N:0]                  ce_c;
    logic                        fix_reg  [0:N];
    logic signed [VW-1:0]        vx_reg   [0:N];
    logic signed [VW-1:0]        vy_reg   [0:N];
    logic signed [ANGLE_W-1:0]   z_reg    [0:N];
    logic signed [VW-1:0]        vx_next  [0:N];
    logic signed [VW-1:0]        vy_next  [0:N];
    logic signed [ANGLE_W-1:0]   z_next   [0:N];
    logic                        fix_next [0:N];

    logic                        vm_reg, vr_reg, vo_reg;
    logic                        ce_m, ce_r, ce_o;
    logic signed [PW-1:0]        mul_reg, mul_next;
    logic signed [SW-1:0]        hsum_reg, hsum_next;
    logic [HEADING_W-1:0]        heading_reg, heading_next;

    logic signed [SAMPLE_W-1:0]  xs, ys;
    logic signed [AW-1:0]        a_in, b_in, a_adj, b_adj;
    logic [PW-1:0]               rnd;
    logic signed [HW-1:0]        h_rnd;
    logic signed [SW:0]          h_fold;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_reg <= 1'b0;
            decl_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SWAP_X_Y:    swap_reg <= cfg_wdata[0];
                CFG_DECLINATION: decl_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // stall chain: a stage advances when empty or when its successor advances
    always_comb begin
        ce_o = !vo_reg || m_tready;
        ce_r = !vr_reg || ce_o;
        ce_m = !vm_reg || ce_r;
        ce_c[N] = !v_reg[N] || ce_m;
        for (int k = N - 1; k >= 0; k--) begin
            ce_c[k] = !v_reg[k] || ce_c[k+1];
        end
    end

    assign s_tready = ce_c[0];

    // setup: swap, negate x, fold the left half plane
    always_comb begin
        xs = swap_reg ? $signed(s_tdata[31:16]) : $signed(s_tdata[15:0]);
        ys = swap_reg ? $signed(s_tdata[15:0])  : $signed(s_tdata[31:16]);
        a_in = -AW'(xs);
        b_in = AW'(ys);
        fix_next[0] = (xs == '0);
        a_adj = a_in;
        b_adj = b_in;
        z_next[0] = '0;
        if (fix_next[0]) begin
            a_adj = '0;
            b_adj = '0;
            z_next[0] = b_in[AW-1] ? Z_HALF : '0;
        end else if (b_in[AW-1]) begin
            a_adj = -a_in;
            b_adj = -b_in;
            z_next[0] = a_in[AW-1] ? -Z_HALF : Z_HALF;
        end
        vx_next[0] = {{(VW-AW-N){b_adj[AW-1]}}, b_adj, {N{1'b0}}};
        vy_next[0] = {{(VW-AW-N){a_adj[AW-1]}}, a_adj, {N{1'b0}}};

        // CORDIC vectoring steps, one per stage
        for (int k = 1; k <= N; k++) begin
            fix_next[k] = fix_reg[k-1];
            vx_next[k]  = vx_reg[k-1];
            vy_next[k]  = vy_reg[k-1];
            z_next[k]   = z_reg[k-1];
            if (!fix_reg[k-1]) begin
                if (vy_reg[k-1] > 0) begin
                    vx_next[k] = vx_reg[k-1] + (vy_reg[k-1] >>> (k - 1));
                    vy_next[k] = vy_reg[k-1] - (vx_reg[k-1] >>> (k - 1));
                    z_next[k]  = z_reg[k-1] + $signed({1'b0, ATAN_TURN[k-1]});
                end else begin
                    vx_next[k] = vx_reg[k-1] - (vy_reg[k-1] >>> (k - 1));
                    vy_next[k] = vy_reg[k-1] + (vx_reg[k-1] >>> (k - 1));
                    z_next[k]  = z_reg[k-1] - $signed({1'b0, ATAN_TURN[k-1]});
                end
            end
        end
    end

    // scale, round, add declination, wrap
    always_comb begin
        mul_next  = z_reg[N] * FULL_S;
        rnd       = mul_reg + ROUND_C;
        h_rnd     = $signed(rnd[PW-1:32]);
        hsum_next = SW'(h_rnd) + SW'(decl_reg);
        h_fold    = (SW+1)'(hsum_reg);
        if (h_fold < 0) begin
            h_fold = h_fold + FULL_F;
        end
        if (h_fold > FULL_F) begin
            h_fold = h_fold - FULL_F;
        end
        if (h_fold < 0) begin
            h_fold = '0;
        end
        if (h_fold > FULL_F) begin
            h_fold = FULL_F;
        end
        heading_next = h_fold[HEADING_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (ce_c[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k <= N; k++) begin
                if (ce_c[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (ce_m) begin
                vm_reg <= v_reg[N];
            end
            if (ce_r) begin
                vr_reg <= vm_reg;
            end
            if (ce_o) begin
                vo_reg <= vr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= N; k++) begin
            if (ce_c[k]) begin
                fix_reg[k] <= fix_next[k];
                vx_reg[k]  <= vx_next[k];
                vy_reg[k]  <= vy_next[k];
                z_reg[k]   <= z_next[k];
            end
        end
        if (ce_m) begin
            mul_reg <= mul_next;
        end
        if (ce_r) begin
            hsum_reg <= hsum_next;
        end
        if (ce_o) begin
            heading_reg <= heading_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = heading_reg;

`ifndef SYNTHESIS
    a_front_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[0] |-> s_tready)
        else $error("front stage empty but input not ready");

    a_axis_angle_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[N] && fix_reg[N]) |-> (z_reg[N] == '0 || z_reg[N] == Z_HALF))
        else $error("on-axis angle changed inside the CORDIC stages");

    a_vx_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[N] && !fix_reg[N]) |-> !vx_reg[N][VW-1])
        else $error("CORDIC x component went negative");

    a_out_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (vr_reg && ce_o) |=> m_tvalid)
        else $error("rounded word lost on its way to the output");
`endif

endmodule
